// File: rtl/cartridge_bank_controller_unit_macros.svh
// assertion helpers shared by the cartridge bank controller rtl
`ifndef CARTRIDGE_BANK_CONTROLLER_UNIT_MACROS_SVH
`define CARTRIDGE_BANK_CONTROLLER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CBC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define CBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/cbc_pkg.sv
package cbc_pkg;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_MBC1 = 2'd1,
        KIND_MBC3 = 2'd2,
        KIND_MBC5 = 2'd3
    } cbc_kind_t;

    typedef enum logic [2:0] {
        TGT_NONE   = 3'd0,
        TGT_ROM    = 3'd1,
        TGT_RAM_RD = 3'd2,
        TGT_RAM_WR = 3'd3,
        TGT_FF     = 3'd4,
        TGT_00     = 3'd5
    } cbc_target_t;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_KIND       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BANK_COUNT = 2'd1;

    // cpu_address[15:13] of the external ram window
    localparam logic [2:0] REGION_RAM = 3'b101;

    // cpu_address[14:13] of the register windows below 0x8000
    localparam logic [1:0] REG_RAM_EN   = 2'b00;
    localparam logic [1:0] REG_ROM_BANK = 2'b01;
    localparam logic [1:0] REG_UPPER    = 2'b10;
    localparam logic [1:0] REG_MODE     = 2'b11;

    localparam logic [3:0] RAM_EN_KEY      = 4'hA;
    localparam logic [7:0] CLOCK_SEL_FIRST = 8'h08;
    localparam logic [7:0] CLOCK_SEL_LAST  = 8'h0C;
    localparam logic [7:0] MBC3_RAM_SEL_MAX = 8'h03;

    typedef struct packed {
        logic        operation;
        logic [15:0] cpu_address;
        logic [7:0]  write_data;
    } cbc_req_t;

    typedef struct packed {
        cbc_target_t target;
        logic [22:0] physical_address;
        logic [7:0]  ram_write_data;
    } cbc_rsp_t;

    typedef struct packed {
        cbc_kind_t       kind;
        logic [4:0]      ram_bank_count;
    } cbc_cfg_t;

endpackage

// File: rtl/cbc_xlate.sv
`include "cartridge_bank_controller_unit_macros.svh"

module cbc_xlate (
    input  logic              clk,
    input  logic              rst_n,
    input  cbc_pkg::cbc_cfg_t cfg,
    input  logic              fire,
    input  cbc_pkg::cbc_req_t req,
    output cbc_pkg::cbc_rsp_t rsp
);
    import cbc_pkg::*;

    logic       ram_enabled_reg, ram_enabled_next;
    logic [8:0] rom_bank_reg, rom_bank_next;
    logic [7:0] upper_bank_reg, upper_bank_next;
    logic       banking_mode_reg, banking_mode_next;

    logic       is_write;
    logic [15:0] addr;
    logic [7:0] wdata;
    logic [8:0] rom_sel;
    logic [1:0] lo_bank;
    logic [3:0] ram_bank;
    logic       ram_go;

    assign is_write = req.operation;
    assign addr     = req.cpu_address;
    assign wdata    = req.write_data;

    always_comb
    begin
        ram_enabled_next  = ram_enabled_reg;
        rom_bank_next     = rom_bank_reg;
        upper_bank_next   = upper_bank_reg;
        banking_mode_next = banking_mode_reg;
        rsp.target           = TGT_NONE;
        rsp.physical_address = '0;
        rsp.ram_write_data   = '0;
        rom_sel  = '0;
        lo_bank  = '0;
        ram_bank = '0;
        ram_go   = 1'b0;

        if (!addr[15])
        begin
            if (is_write)
            begin
                if (cfg.kind != KIND_NONE)
                begin
                    case (addr[14:13])
                        REG_RAM_EN:
                        begin
                            ram_enabled_next = (wdata[3:0] == RAM_EN_KEY);
                        end
                        REG_ROM_BANK:
                        begin
                            case (cfg.kind)
                                KIND_MBC1:
                                begin
                                    // bank zero is not selectable, it reads as one
                                    rom_bank_next = (wdata[4:0] == 5'd0) ? 9'd1
                                                                         : {4'd0, wdata[4:0]};
                                end
                                KIND_MBC3:
                                begin
                                    rom_bank_next = (wdata[6:0] == 7'd0) ? 9'd1
                                                                         : {2'd0, wdata[6:0]};
                                end
                                default:
                                begin
                                    // mbc5 splits the bank number at 0x3000
                                    if (!addr[12])
                                        rom_bank_next = {rom_bank_reg[8], wdata};
                                    else
                                        rom_bank_next = {wdata[0], rom_bank_reg[7:0]};
                                end
                            endcase
                        end
                        REG_UPPER:
                        begin
                            case (cfg.kind)
                                KIND_MBC1: upper_bank_next = {6'd0, wdata[1:0]};
                                KIND_MBC3: upper_bank_next = wdata;
                                default:   upper_bank_next = {4'd0, wdata[3:0]};
                            endcase
                        end
                        REG_MODE:
                        begin
                            if (cfg.kind == KIND_MBC1)
                                banking_mode_next = wdata[0];
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            else if (!addr[14])
            begin
                if (cfg.kind == KIND_MBC1 && banking_mode_reg)
                    lo_bank = upper_bank_reg[1:0];
                rsp.target           = TGT_ROM;
                rsp.physical_address = {2'd0, lo_bank, 5'd0, addr[13:0]};
            end
            else
            begin
                case (cfg.kind)
                    KIND_MBC1: rom_sel = {2'd0, upper_bank_reg[1:0], rom_bank_reg[4:0]};
                    KIND_MBC3: rom_sel = {2'd0, rom_bank_reg[6:0]};
                    KIND_MBC5: rom_sel = rom_bank_reg;
                    default:   rom_sel = 9'd1;
                endcase
                rsp.target           = TGT_ROM;
                rsp.physical_address = {rom_sel, addr[13:0]};
            end
        end
        else if (addr[15:13] == REGION_RAM)
        begin
            if (cfg.kind == KIND_NONE || !ram_enabled_reg)
            begin
                rsp.target = is_write ? TGT_NONE : TGT_FF;
            end
            else
            begin
                case (cfg.kind)
                    KIND_MBC1:
                    begin
                        ram_go = 1'b1;
                        // out-of-range bank falls back to bank 0
                        if (banking_mode_reg && ({3'd0, upper_bank_reg[1:0]} < cfg.ram_bank_count))
                            ram_bank = {2'd0, upper_bank_reg[1:0]};
                    end
                    KIND_MBC3:
                    begin
                        if (upper_bank_reg > MBC3_RAM_SEL_MAX)
                        begin
                            if (is_write)
                                rsp.target = TGT_NONE;
                            else if (upper_bank_reg >= CLOCK_SEL_FIRST
                                     && upper_bank_reg <= CLOCK_SEL_LAST)
                                rsp.target = TGT_00;
                            else
                                rsp.target = TGT_FF;
                        end
                        else
                        begin
                            ram_go   = 1'b1;
                            ram_bank = {2'd0, upper_bank_reg[1:0]};
                        end
                    end
                    default:
                    begin
                        ram_go   = 1'b1;
                        ram_bank = upper_bank_reg[3:0];
                    end
                endcase
                if (ram_go)
                begin
                    rsp.target           = is_write ? TGT_RAM_WR : TGT_RAM_RD;
                    rsp.physical_address = {6'd0, ram_bank, addr[12:0]};
                    rsp.ram_write_data   = is_write ? wdata : 8'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_enabled_reg  <= 1'b0;
            rom_bank_reg     <= 9'd1;
            upper_bank_reg   <= 8'd0;
            banking_mode_reg <= 1'b0;
        end
        else if (fire)
        begin
            ram_enabled_reg  <= ram_enabled_next;
            rom_bank_reg     <= rom_bank_next;
            upper_bank_reg   <= upper_bank_next;
            banking_mode_reg <= banking_mode_next;
        end
    end

    `CBC_ASSERT_NEXT(a_rom_bank_nonzero,
        fire && is_write && !addr[15] && addr[14:13] == REG_ROM_BANK
            && (cfg.kind == KIND_MBC1 || cfg.kind == KIND_MBC3),
        rom_bank_reg != 9'd0, "mbc1/mbc3 rom bank written as zero")
    `CBC_ASSERT_NOW(a_ram_needs_enable,
        rsp.target == TGT_RAM_RD || rsp.target == TGT_RAM_WR,
        ram_enabled_reg && cfg.kind != KIND_NONE, "ram access while ram disabled")

endmodule

// File: rtl/cartridge_bank_controller_unit.sv
// Cartridge bank controller: translates cpu bus requests through mbc1/mbc3/mbc5
// bank registers into a target code and a rom or external ram byte address, one
// request per clock while out_stall does not block a full result register. Each
// request passes an input register, then the result register, with the bank
// register update and the translation in the single logic stage between them.
// A register write takes effect for the very next request. Set controller_kind
// and ram_bank_count through the cfg port only while no request is in flight.
`include "cartridge_bank_controller_unit_macros.svh"

module cartridge_bank_controller_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  cbc_pkg::cbc_req_t                   in_req,
    output logic                                out_valid,
    input  logic                                out_stall,
    output cbc_pkg::cbc_rsp_t                   out_rsp,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cbc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cbc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import cbc_pkg::*;

    cbc_kind_t  kind_reg, kind_next;
    logic [4:0] bank_count_reg, bank_count_next;

    logic     in_valid_reg, in_valid_next;
    cbc_req_t in_req_reg;
    logic     out_valid_reg, out_valid_next;
    cbc_rsp_t out_rsp_reg;

    cbc_cfg_t cfg;
    cbc_rsp_t rsp;
    logic     fire;
    logic     accept_in;

    assign cfg_ready = 1'b1;
    assign cfg.kind           = kind_reg;
    assign cfg.ram_bank_count = bank_count_reg;

    // stage advances when the result register is empty or being drained
    assign fire      = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !fire;
    assign accept_in = in_valid && !in_stall;

    assign in_valid_next  = accept_in || (in_valid_reg && !fire);
    assign out_valid_next = fire || (out_valid_reg && out_stall);

    assign out_valid = out_valid_reg;
    assign out_rsp   = out_rsp_reg;

    always_comb
    begin
        kind_next       = kind_reg;
        bank_count_next = bank_count_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_IDX_KIND:       kind_next       = cbc_kind_t'(cfg_data[1:0]);
                CFG_IDX_BANK_COUNT: bank_count_next = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    cbc_xlate u_xlate (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .fire  (fire),
        .req   (in_req_reg),
        .rsp   (rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg       <= KIND_NONE;
            bank_count_reg <= 5'd0;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            kind_reg       <= kind_next;
            bank_count_reg <= bank_count_next;
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
            in_req_reg <= in_req;
        if (fire)
            out_rsp_reg <= rsp;
    end

    `CBC_ASSERT_NOW(a_stall_only_when_full, in_stall,
        in_valid_reg && out_valid_reg && out_stall, "input stalled without a blocked result")
    `CBC_ASSERT_NOW(a_wdata_only_on_write, out_valid && out_rsp.target != TGT_RAM_WR,
        out_rsp.ram_write_data == 8'd0, "write data on a non-write result")
    `CBC_ASSERT_NOW(a_addr_only_on_access,
        out_valid && (out_rsp.target == TGT_NONE || out_rsp.target == TGT_FF
            || out_rsp.target == TGT_00),
        out_rsp.physical_address == 23'd0, "address on a result without access")

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import cbc_pkg::*;

    localparam bit OP_READ  = 1'b0;
    localparam bit OP_WRITE = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

    class bank_map_checker;
        cbc_kind_t   kind;
        logic [4:0]  bank_count;
        logic        ram_on;
        logic [8:0]  rom_sel;
        logic [7:0]  upper_sel;
        logic        mode_sel;
        cbc_rsp_t    expected_rsp[$];
        int          errors;

        function new();
            kind       = KIND_NONE;
            bank_count = '0;
            ram_on     = 1'b0;
            rom_sel    = 9'd1;
            upper_sel  = '0;
            mode_sel   = 1'b0;
            errors     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_IDX_KIND:       kind = cbc_kind_t'(data[1:0]);
                CFG_IDX_BANK_COUNT: bank_count = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_rsp.size();
        endfunction

        function void set_bank_reg(logic [15:0] a, logic [7:0] v);
            case (a[14:13])
                REG_RAM_EN: ram_on = (v[3:0] == RAM_EN_KEY);
                REG_ROM_BANK:
                begin
                    if (kind == KIND_MBC1)
                    begin
                        rom_sel = {4'b0, v[4:0]};
                        if (v[4:0] == 5'd0)
                            rom_sel = 9'd1;
                    end
                    else if (kind == KIND_MBC3)
                    begin
                        rom_sel = {2'b0, v[6:0]};
                        if (v[6:0] == 7'd0)
                            rom_sel = 9'd1;
                    end
                    // mbc5 splits the window: low byte, then bit 8
                    else if (!a[12])
                        rom_sel[7:0] = v;
                    else
                        rom_sel[8] = v[0];
                end
                REG_UPPER:
                begin
                    if (kind == KIND_MBC1)
                        upper_sel = {6'b0, v[1:0]};
                    else if (kind == KIND_MBC3)
                        upper_sel = v;
                    else
                        upper_sel = {4'b0, v[3:0]};
                end
                REG_MODE:
                begin
                    if (kind == KIND_MBC1)
                        mode_sel = v[0];
                end
                default: ;
            endcase
        endfunction

        function cbc_rsp_t map_access(cbc_req_t r);
            cbc_rsp_t    rsp;
            int unsigned a;
            int unsigned bank;
            rsp  = '0;
            a    = r.cpu_address;
            bank = 0;
            if (a < 'h8000)
            begin
                if (r.operation)
                begin
                    if (kind != KIND_NONE)
                        set_bank_reg(r.cpu_address, r.write_data);
                    return rsp;
                end
                rsp.target = TGT_ROM;
                if (a < 'h4000)
                begin
                    if (kind == KIND_MBC1 && mode_sel)
                        bank = int'(upper_sel[1:0]) * 32;
                    rsp.physical_address = 23'(a + bank * 'h4000);
                end
                else
                begin
                    case (kind)
                        KIND_NONE: bank = 1;   // plain cartridge maps straight through
                        KIND_MBC1: bank = int'(rom_sel[4:0]) + int'(upper_sel[1:0]) * 32;
                        KIND_MBC3: bank = rom_sel[6:0];
                        default:   bank = rom_sel;
                    endcase
                    rsp.physical_address = 23'(bank * 'h4000 + a - 'h4000);
                end
                return rsp;
            end
            if (a < 'hA000 || a > 'hBFFF)
                return rsp;
            if (kind == KIND_NONE || !ram_on)
            begin
                if (!r.operation)
                    rsp.target = TGT_FF;
                return rsp;
            end
            case (kind)
                KIND_MBC1:
                begin
                    if (mode_sel)
                    begin
                        bank = upper_sel[1:0];
                        if (bank >= bank_count)
                            bank = 0;
                    end
                end
                KIND_MBC3:
                begin
                    if (upper_sel > MBC3_RAM_SEL_MAX)
                    begin
                        if (!r.operation)
                            rsp.target = (upper_sel >= CLOCK_SEL_FIRST &&
                                          upper_sel <= CLOCK_SEL_LAST) ? TGT_00 : TGT_FF;
                        return rsp;
                    end
                    bank = upper_sel;
                end
                default: bank = upper_sel[3:0];
            endcase
            rsp.physical_address = 23'(a - 'hA000 + bank * 'h2000);
            if (r.operation)
            begin
                rsp.target         = TGT_RAM_WR;
                rsp.ram_write_data = r.write_data;
            end
            else
                rsp.target = TGT_RAM_RD;
            return rsp;
        endfunction

        function void note_access(cbc_req_t r);
            expected_rsp.push_back(map_access(r));
        endfunction

        function void check_result(cbc_rsp_t got);
            cbc_rsp_t want;
            if (expected_rsp.size() == 0)
            begin
                $error("unexpected result: target %0d address %h", got.target,
                       got.physical_address);
                errors++;
                return;
            end
            want = expected_rsp.pop_front();
            if (got.target !== want.target)
            begin
                $error("target: expected %0d, got %0d", want.target, got.target);
                errors++;
            end
            if (got.physical_address !== want.physical_address)
            begin
                $error("physical_address: expected %h, got %h", want.physical_address,
                       got.physical_address);
                errors++;
            end
            if (got.ram_write_data !== want.ram_write_data)
            begin
                $error("ram_write_data: expected %h, got %h", want.ram_write_data,
                       got.ram_write_data);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    cbc_req_t              in_req;
    logic                  out_valid;
    logic                  out_stall;
    cbc_rsp_t              out_rsp;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bank_map_checker board;
    bit              calm;
    int              idle_odds;

    cartridge_bank_controller_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_req    (in_req),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_rsp   (out_rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    // result side: check every accepted result, stall in random bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                board.check_result(out_rsp);
            if (stall_left > 0)
                stall_left--;
            else if (!calm && $urandom_range(0, idle_odds) == 0)
                stall_left = $urandom_range(1, 8);
            out_stall <= (stall_left != 0);
        end
    end

    task automatic send_access(input cbc_req_t r);
        in_valid <= 1'b1;
        in_req   <= r;
        do
            @(posedge clk);
        while (in_stall);
        board.note_access(r);
        if (!calm && $urandom_range(0, idle_odds) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic acc(input bit op, input logic [15:0] addr, input logic [7:0] data);
        cbc_req_t r;
        r.operation   = op;
        r.cpu_address = addr;
        r.write_data  = data;
        send_access(r);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] kind_val,
                                input logic [CFG_DATA_W-1:0] banks_val, input bit stray);
        logic [CFG_IDX_W-1:0]  idx_list[$];
        logic [CFG_DATA_W-1:0] val_list[$];
        idx_list = '{CFG_IDX_KIND, CFG_IDX_BANK_COUNT};
        val_list = '{kind_val, banks_val};
        if (stray)
        begin
            idx_list.push_back(CFG_IDX_UNUSED);
            val_list.push_back(CFG_DATA_W'($urandom));
        end
        foreach (idx_list[k])
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx_list[k];
            cfg_data  <= val_list[k];
            do
                @(posedge clk);
            while (!cfg_ready);
            board.write_reg(idx_list[k], val_list[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    // mostly bank register writes, rom reads and ram window accesses
    function automatic cbc_req_t random_access();
        cbc_req_t    r;
        int unsigned pick;
        r.operation   = 1'($urandom_range(0, 1));
        r.cpu_address = 16'($urandom);
        r.write_data  = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            r.operation      = OP_WRITE;
            r.cpu_address[15] = 1'b0;
            if (r.cpu_address[14:13] == REG_RAM_EN && $urandom_range(0, 1) == 1)
                r.write_data[3:0] = RAM_EN_KEY;
            if (r.cpu_address[14:13] == REG_UPPER && $urandom_range(0, 2) != 0)
                r.write_data = 8'($urandom_range(0, 15));
        end
        else if (pick < 55)
        begin
            r.operation       = OP_READ;
            r.cpu_address[15] = 1'b0;
        end
        else if (pick < 88)
            r.cpu_address[15:13] = REGION_RAM;
        return r;
    endfunction

    initial
    begin
        logic [CFG_DATA_W-1:0] banks_val;
        board     = new();
        calm      = 1'b0;
        idle_odds = 7;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_req    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // no controller after reset
        acc(OP_READ,  16'h0000, 8'h00);
        acc(OP_READ,  16'h7FFF, 8'hFF);
        acc(OP_WRITE, 16'h0000, 8'h0A);
        acc(OP_READ,  16'hA000, 8'h00);
        acc(OP_WRITE, 16'hFFFF, 8'hFF);
        settle();

        // mbc5, kind written with spare upper bits set
        program_regs(5'h1F, 5'd16, 1'b1);
        acc(OP_WRITE, 16'h2000, 8'hFF);
        acc(OP_WRITE, 16'h3FFF, 8'h01);
        acc(OP_READ,  16'h7FFF, 8'h00);
        acc(OP_WRITE, 16'h2FFF, 8'h00);
        acc(OP_WRITE, 16'h3000, 8'h00);
        acc(OP_READ,  16'h4000, 8'h00);
        acc(OP_WRITE, 16'h1FFF, 8'h3A);
        acc(OP_WRITE, 16'h5FFF, 8'hFF);
        acc(OP_WRITE, 16'hBFFF, 8'hFF);
        acc(OP_WRITE, 16'h6000, 8'h01);
        settle();

        // mbc1 picks up what mbc5 left in the bank registers
        program_regs(CFG_DATA_W'(KIND_MBC1), 5'd2, 1'b0);
        acc(OP_READ,  16'h4000, 8'h00);
        acc(OP_WRITE, 16'h6000, 8'h01);
        acc(OP_READ,  16'h0000, 8'h00);
        acc(OP_READ,  16'hA000, 8'h00);
        acc(OP_WRITE, 16'h2000, 8'hE0);
        acc(OP_WRITE, 16'h4000, 8'h01);
        acc(OP_READ,  16'hB000, 8'h00);
        acc(OP_WRITE, 16'h0000, 8'h00);
        acc(OP_READ,  16'hA000, 8'h00);
        settle();

        // mbc3 clock and unmapped selects
        program_regs(CFG_DATA_W'(KIND_MBC3), 5'd4, 1'b0);
        acc(OP_WRITE, 16'h0000, 8'h0A);
        acc(OP_WRITE, 16'h4000, 8'h0C);
        acc(OP_READ,  16'hA000, 8'h00);
        acc(OP_WRITE, 16'hA000, 8'h77);
        acc(OP_WRITE, 16'h4000, 8'h04);
        acc(OP_READ,  16'hBFFF, 8'h00);
        acc(OP_WRITE, 16'h2000, 8'h80);
        acc(OP_READ,  16'h4000, 8'h00);
        acc(OP_WRITE, 16'h7FFF, 8'h01);
        settle();

        for (int ph = 0; ph < 10; ph++)
        begin
            if (ph == 1)
                banks_val = 5'd16;
            else if (ph == 5)
                banks_val = 5'd0;
            else
                banks_val = 5'($urandom_range(0, 16));
            idle_odds = (ph % 3 == 2) ? 40 : $urandom_range(2, 10);
            calm      = (ph == 9);
            program_regs({3'($urandom), 2'(ph % 4)}, banks_val, ph == 3);
            repeat (130) send_access(random_access());
            settle();
        end

        repeat (6) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
